// File: sv/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the button press classifier
// Key count, per-key state record, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

   localparam int unsigned NUM_KEYS = 3;

   localparam int unsigned COUNT_W = 16;
   localparam int unsigned AGE_W   = 13;
   localparam int unsigned HOLD_W  = 12;
   localparam int unsigned KEY_W   = 2;
   localparam int unsigned CSR_AW  = 2;
   localparam int unsigned CSR_DW  = 16;

   localparam logic [COUNT_W-1:0] SHORT_TICKS_RST = 16'd200;
   localparam logic [COUNT_W-1:0] LONG_TICKS_RST  = 16'd12000;
   localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST  = 12'd400;
   localparam logic [AGE_W-1:0]   AGE_LIMIT       = 13'd4000;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

   typedef enum logic [CSR_AW-1:0] {
      CSR_SHORT_TICKS = 2'd0,
      CSR_LONG_TICKS  = 2'd1,
      CSR_HOLD_TICKS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               prev_level;
      logic [COUNT_W-1:0] hold_count;
      logic               held_flag;
      logic               short_flag;
      logic               long_flag;
      logic [AGE_W-1:0]   short_age;
      logic [AGE_W-1:0]   long_age;
   } key_state_type;

   localparam int unsigned STATE_W = $bits(key_state_type);

endpackage

`default_nettype wire

// File: sv/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier: short and long press detection for several keys
// Per-key state kept in a RAM, updated read-modify-write once per sample.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one pin sample per beat: the key index and its active-low
//   level. rsp_ returns one beat per sample with the key index and that
//   key's held, short and long flags after the update.
//   A sample passes the state RAM read and then the output register before
//   its response is valid. One sample is taken every cycle unless rsp_
//   stalls; samples of the same key may follow back to back, the
//   freshly written state is forwarded around the RAM.
//   A stalled rsp_ holds the output register; the update stage then holds
//   and req_tready drops only when both are occupied.
//   Reset clears the control state, the registers to their defaults and the
//   per-key valid bits, so every key starts from an all-zero state at once.
//   Samples for keys >= NUM_KEYS change nothing and return all flags clear.
//   csr_ writes apply at once and the user makes them while idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_classifier (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // req_tdata: [1:0] key_index, [2] pin_level, [7:3] zero
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [7:0]                  req_tdata,
   // rsp_tdata: [1:0] key_id, [2] held, [3] short_press, [4] long_press, [7:5] zero
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic      [7:0]                  rsp_tdata,
   input  wire logic                        csr_we,
   input  wire logic [bpc_pkg::CSR_AW-1:0]  csr_addr,
   input  wire logic [bpc_pkg::CSR_DW-1:0]  csr_wdata
);

   localparam int unsigned AW = (bpc_pkg::NUM_KEYS > 1) ? $clog2(bpc_pkg::NUM_KEYS) : 1;

   // configuration
   logic [bpc_pkg::COUNT_W-1:0] short_ticks_ff, long_ticks_ff;
   logic [bpc_pkg::HOLD_W-1:0]  hold_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ticks_ff <= bpc_pkg::SHORT_TICKS_RST;
         long_ticks_ff  <= bpc_pkg::LONG_TICKS_RST;
         hold_ticks_ff  <= bpc_pkg::HOLD_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            bpc_pkg::CSR_SHORT_TICKS: short_ticks_ff <= csr_wdata;
            bpc_pkg::CSR_LONG_TICKS:  long_ticks_ff  <= csr_wdata;
            bpc_pkg::CSR_HOLD_TICKS:  hold_ticks_ff  <= csr_wdata[bpc_pkg::HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   logic req_key_ok;
   logic [bpc_pkg::KEY_W-1:0] req_key;
   logic req_accept, advance, s1_fire, wr_en;

   logic                       s1_valid_ff, s1_valid_in;
   logic [bpc_pkg::KEY_W-1:0]  s1_key_ff;
   logic [AW-1:0]              s1_addr_ff;
   logic                       s1_pin_ff, s1_ok_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_data_ff;

   assign req_key    = req_tdata[bpc_pkg::KEY_W-1:0];
   assign req_key_ok = (32'(req_key) < bpc_pkg::NUM_KEYS);
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign s1_fire    = s1_valid_ff && advance;
   assign wr_en      = s1_fire && s1_ok_ff;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_key_ff  <= req_key;
         s1_addr_ff <= AW'(req_key);
         s1_pin_ff  <= req_tdata[2];
         s1_ok_ff   <= req_key_ok;
      end
   end

   // state RAM with per-key valid bits and write forwarding
   bpc_pkg::key_state_type ram_rd, cur, nxt;
   bpc_pkg::key_state_type fwd_state_ff;
   logic [AW-1:0]          fwd_addr_ff;
   logic                   fwd_valid_ff;
   logic [bpc_pkg::NUM_KEYS-1:0] key_valid_ff, key_valid_in;
   logic [bpc_pkg::STATE_W-1:0] ram_rd_bits;

   bpc_ram #(
      .WIDTH (bpc_pkg::STATE_W),
      .DEPTH (bpc_pkg::NUM_KEYS),
      .AW    (AW)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (nxt),
      .rd_en   (req_accept),
      .rd_addr (AW'(req_key)),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd = ram_rd_bits;

   always_comb begin
      key_valid_in = key_valid_ff;
      if (wr_en) begin
         key_valid_in[s1_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         key_valid_ff <= key_valid_in;
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   // the last write always holds the newest state of its key
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_state_ff <= nxt;
         fwd_addr_ff  <= s1_addr_ff;
      end
   end

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         cur = fwd_state_ff;
      end else if (key_valid_ff[s1_addr_ff]) begin
         cur = ram_rd;
      end else begin
         cur = '0;
      end
   end

   // state update
   logic [bpc_pkg::COUNT_W-1:0] count_inc;

   always_comb begin
      nxt       = cur;
      count_inc = (cur.hold_count < bpc_pkg::COUNT_MAX) ?
                  cur.hold_count + 16'd1 : cur.hold_count;
      case ({cur.prev_level, s1_pin_ff})
         2'b10: begin
            nxt.held_flag = 1'b0;
         end
         2'b01: begin
            if (cur.hold_count >= long_ticks_ff) begin
               nxt.held_flag  = 1'b0;
               nxt.hold_count = '0;
            end else if (cur.hold_count >= short_ticks_ff) begin
               nxt.short_flag = 1'b1;
               nxt.held_flag  = 1'b0;
               nxt.hold_count = '0;
            end
         end
         2'b00: begin
            nxt.hold_count = count_inc;
            if (count_inc >= long_ticks_ff) begin
               nxt.long_flag = 1'b1;
            end else begin
               nxt.held_flag = 1'b1;
            end
         end
         default: begin
            nxt.held_flag = 1'b0;
            // age the short flag
            if ((cur.short_age >= {1'b0, hold_ticks_ff}) && cur.short_flag) begin
               nxt.short_flag = 1'b0;
               nxt.short_age  = '0;
            end
            if (nxt.short_flag) begin
               nxt.short_age = nxt.short_age + 13'd1;
            end
            if (nxt.short_age > bpc_pkg::AGE_LIMIT) begin
               nxt.short_age  = '0;
               nxt.short_flag = 1'b0;
            end
            // age the long flag
            if ((cur.long_age >= {1'b0, hold_ticks_ff}) && cur.long_flag) begin
               nxt.long_flag = 1'b0;
               nxt.long_age  = '0;
            end
            if (nxt.long_flag) begin
               nxt.long_age = nxt.long_age + 13'd1;
            end
            if (nxt.long_age > bpc_pkg::AGE_LIMIT) begin
               nxt.long_age  = '0;
               nxt.long_flag = 1'b0;
            end
         end
      endcase
      nxt.prev_level = s1_pin_ff;
   end

   // output register
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff <= {3'b000,
                         nxt.long_flag  & s1_ok_ff,
                         nxt.short_flag & s1_ok_ff,
                         nxt.held_flag  & s1_ok_ff,
                         s1_key_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(s1_key_ff) < bpc_pkg::NUM_KEYS))
      else $error("state write for a key out of range");

   a_fwd_tracks_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (fwd_valid_ff && (fwd_addr_ff == $past(s1_addr_ff))))
      else $error("forwarding register missed a write");

   a_bad_key_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (32'(rsp_data_ff[1:0]) >= bpc_pkg::NUM_KEYS))
      |-> (rsp_data_ff[4:2] == 3'b000))
      else $error("flags set for a key out of range");

   a_written_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> key_valid_ff[$past(s1_addr_ff)])
      else $error("valid bit not set after write");

endmodule

`default_nettype wire

// File: sv/bpc_ram.sv
// ----------------------------------------------------------------------------
// bpc_ram: generic single-write, single-read RAM
// One write port, one read port with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: tb/button_press_classifier_test.sv
// ----------------------------------------------------------------------------
// button_press_classifier_test: self-checking bench for the press classifier
// Drives pin samples for every key index, predicts the per-key held, short and
// long flags in a behavioural copy of the key state, and checks each response
// beat in order. Covers directed press patterns, register extremes, a long
// output stall and random traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_press_classifier_test;

   localparam int unsigned NUM_KEYS    = bpc_pkg::NUM_KEYS;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned MAX_REPORTS = 10;

   localparam logic [bpc_pkg::KEY_W-1:0]  KEY_ABSENT = 2'd3;
   localparam logic [bpc_pkg::CSR_AW-1:0] CSR_UNUSED = 2'd3;
   localparam logic                       PRESSED    = 1'b0;
   localparam logic                       RELEASED   = 1'b1;

   // {previous level, current level}
   localparam logic [1:0] STILL_HELD     = 2'b00;
   localparam logic [1:0] EDGE_RELEASE   = 2'b01;
   localparam logic [1:0] EDGE_PRESS     = 2'b10;
   localparam logic [1:0] STILL_RELEASED = 2'b11;

   typedef struct packed {
      logic                      long_press;
      logic                      short_press;
      logic                      held;
      logic [bpc_pkg::KEY_W-1:0] key_id;
   } key_flags_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [7:0]                 rsp_tdata;
   logic                       csr_we     = 1'b0;
   logic [bpc_pkg::CSR_AW-1:0] csr_addr   = '0;
   logic [bpc_pkg::CSR_DW-1:0] csr_wdata  = '0;

   // behavioural copy of the block
   bpc_pkg::key_state_type        key_model [NUM_KEYS];
   logic [bpc_pkg::COUNT_W-1:0]   short_ticks;
   logic [bpc_pkg::COUNT_W-1:0]   long_ticks;
   logic [bpc_pkg::HOLD_W-1:0]    hold_ticks;
   key_flags_type                 expected_flags [$];

   // stimulus plan per key for well-formed press and release runs
   logic                 plan_level [NUM_KEYS];
   int unsigned          plan_left  [NUM_KEYS];

   int unsigned req_gap_pct   = 0;
   int unsigned rsp_stall_pct = 0;
   bit          stall_request = 1'b0;
   int unsigned stall_left    = 0;

   int unsigned cycle_count     = 0;
   int unsigned failures        = 0;
   int unsigned samples_sent    = 0;
   int unsigned results_checked = 0;
   int unsigned settings_used   = 0;

   button_press_classifier u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_flags.size());
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic void age_flag(inout logic [bpc_pkg::AGE_W-1:0] age,
                                    inout logic flag);
      if (age >= hold_ticks && flag) begin
         flag = 1'b0;
         age  = '0;
      end
      if (flag)
         age = age + 1'b1;
      if (age > bpc_pkg::AGE_LIMIT) begin
         age  = '0;
         flag = 1'b0;
      end
   endfunction

   function automatic key_flags_type classify_sample(logic [bpc_pkg::KEY_W-1:0] key,
                                                     logic pin);
      key_flags_type          flags;
      bpc_pkg::key_state_type st;
      flags = '0;
      flags.key_id = key;
      if (key >= NUM_KEYS)
         return flags;
      st = key_model[key];
      case ({st.prev_level, pin})
         EDGE_PRESS: st.held_flag = 1'b0;
         EDGE_RELEASE: begin
            if (st.hold_count >= long_ticks) begin
               st.held_flag  = 1'b0;
               st.hold_count = '0;
            end else if (st.hold_count >= short_ticks) begin
               st.short_flag = 1'b1;
               st.held_flag  = 1'b0;
               st.hold_count = '0;
            end
         end
         STILL_HELD: begin
            if (st.hold_count != bpc_pkg::COUNT_MAX)
               st.hold_count = st.hold_count + 1'b1;
            if (st.hold_count >= long_ticks)
               st.long_flag = 1'b1;
            else
               st.held_flag = 1'b1;
         end
         default: begin
            st.held_flag = 1'b0;
            age_flag(st.short_age, st.short_flag);
            age_flag(st.long_age, st.long_flag);
         end
      endcase
      st.prev_level = pin;
      key_model[key] = st;
      flags.held        = st.held_flag;
      flags.short_press = st.short_flag;
      flags.long_press  = st.long_flag;
      return flags;
   endfunction

   function automatic logic [bpc_pkg::CSR_DW-1:0] rand_csr(input int unsigned hi);
      logic [31:0] pick;
      pick = $urandom_range(hi, 0);
      return pick[bpc_pkg::CSR_DW-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic send_sample(input logic [bpc_pkg::KEY_W-1:0] key, input logic pin);
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, pin, key};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      expected_flags.push_back(classify_sample(key, pin));
      samples_sent++;
   endtask

   task automatic send_run(input logic [bpc_pkg::KEY_W-1:0] key, input logic pin,
                           input int unsigned n);
      repeat (n) send_sample(key, pin);
   endtask

   // wait for every expected beat, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_flags.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_we high; the caller lowers it after the last write
   task automatic write_csr(input logic [bpc_pkg::CSR_AW-1:0] idx,
                            input logic [bpc_pkg::CSR_DW-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         bpc_pkg::CSR_SHORT_TICKS: short_ticks = value;
         bpc_pkg::CSR_LONG_TICKS:  long_ticks  = value;
         bpc_pkg::CSR_HOLD_TICKS:  hold_ticks  = value[bpc_pkg::HOLD_W-1:0];
         default: ;
      endcase
   endtask

   // also pokes the unused index, which must leave every register alone
   task automatic program_thresholds(input logic [bpc_pkg::CSR_DW-1:0] short_v,
                                     input logic [bpc_pkg::CSR_DW-1:0] long_v,
                                     input logic [bpc_pkg::CSR_DW-1:0] hold_v);
      write_csr(bpc_pkg::CSR_SHORT_TICKS, short_v);
      write_csr(CSR_UNUSED, rand_csr(32'hFFFF_FFFF));
      write_csr(bpc_pkg::CSR_LONG_TICKS, long_v);
      write_csr(bpc_pkg::CSR_HOLD_TICKS, hold_v);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   // mostly well-formed press and release runs per key, some noise
   task automatic run_traffic(input int unsigned n);
      logic [bpc_pkg::KEY_W-1:0] key;
      logic                      pin;
      int unsigned               span;
      logic [31:0]               pick;
      repeat (n) begin
         if ($urandom_range(99) < 8) begin
            pick = $urandom_range(3, 0);
            key  = pick[bpc_pkg::KEY_W-1:0];
            pick = $urandom_range(1, 0);
            pin  = pick[0];
         end else begin
            pick = $urandom_range(NUM_KEYS-1, 0);
            key  = pick[bpc_pkg::KEY_W-1:0];
            if (plan_left[key] == 0) begin
               plan_level[key] = ~plan_level[key];
               if (plan_level[key] == PRESSED)
                  span = (long_ticks > 44) ? 48 : long_ticks + 4;
               else
                  span = (hold_ticks > 34) ? 40 : hold_ticks + 6;
               plan_left[key] = $urandom_range(span, 1);
            end
            plan_left[key]--;
            pin = plan_level[key];
         end
         send_sample(key, pin);
      end
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_request) begin
         stall_left    = 300;
         stall_request = 1'b0;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   always @(posedge clock) begin
      key_flags_type seen;
      key_flags_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[4:0];
         if (expected_flags.size() == 0) begin
            note_failure($sformatf("unexpected beat %h", rsp_tdata));
         end else begin
            want = expected_flags.pop_front();
            results_checked++;
            if (seen.key_id !== want.key_id)
               note_failure($sformatf("key_id expected %0d got %0d", want.key_id, seen.key_id));
            if (seen.held !== want.held)
               note_failure($sformatf("key %0d held expected %b got %b",
                                      want.key_id, want.held, seen.held));
            if (seen.short_press !== want.short_press)
               note_failure($sformatf("key %0d short_press expected %b got %b",
                                      want.key_id, want.short_press, seen.short_press));
            if (seen.long_press !== want.long_press)
               note_failure($sformatf("key %0d long_press expected %b got %b",
                                      want.key_id, want.long_press, seen.long_press));
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      // reset thresholds still in force
      send_run(KEY_ABSENT, PRESSED, 1);
      send_run(KEY_ABSENT, RELEASED, 1);
      send_run(2'd0, RELEASED, 1);
      settle();
      program_thresholds(16'd2, 16'd4, 16'd3);
      // short press, then the flag ages out
      send_run(2'd0, RELEASED, 1);
      send_run(2'd0, PRESSED, 4);
      send_run(2'd0, RELEASED, 5);
      // long hold with held flag left standing, then release and age out
      send_run(2'd1, PRESSED, 5);
      send_run(2'd1, RELEASED, 5);
      // release below the short threshold keeps the count
      send_run(2'd2, PRESSED, 1);
      send_run(2'd2, RELEASED, 1);
      send_run(2'd2, PRESSED, 2);
      send_run(2'd2, RELEASED, 1);
      settle();
   endtask

   task automatic test_register_extremes();
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      // zero hold time: a set flag clears on the first released sample after the release edge
      program_thresholds(16'd0, 16'd0, 16'd0);
      run_traffic(25);
      settle();
      program_thresholds(16'd0, 16'hFFFF, 16'hF001);
      run_traffic(25);
      settle();
      program_thresholds(16'hFFFF, 16'd0, 16'h0FA0);
      run_traffic(25);
      settle();
      program_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_traffic(25);
      settle();
   endtask

   task automatic test_backpressure();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      program_thresholds(16'd3, 16'd6, 16'd4);
      stall_request = 1'b1;
      run_traffic(60);
      settle();
   endtask

   task automatic random_phase(input int unsigned gap, input int unsigned stall,
                               input int unsigned n);
      req_gap_pct   = gap;
      rsp_stall_pct = stall;
      program_thresholds(rand_csr(8), rand_csr(16), rand_csr(10));
      run_traffic(n / 2);
      settle();
      program_thresholds(rand_csr(8), rand_csr(16), rand_csr(10));
      run_traffic(n - n / 2);
      settle();
   endtask

   task automatic test_random();
      random_phase(0, 0, 100);
      random_phase(56, 0, 100);
      random_phase(0, 56, 100);
      random_phase(36, 36, 100);
   endtask

   initial begin
      short_ticks = bpc_pkg::SHORT_TICKS_RST;
      long_ticks  = bpc_pkg::LONG_TICKS_RST;
      hold_ticks  = bpc_pkg::HOLD_TICKS_RST;
      for (int i = 0; i < NUM_KEYS; i++) begin
         key_model[i]  = '0;
         plan_level[i] = PRESSED;
         plan_left[i]  = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_extremes();
      test_backpressure();
      test_random();

      repeat (8) @(posedge clock);
      if (expected_flags.size() != 0)
         note_failure($sformatf("%0d results never arrived", expected_flags.size()));
      $display("Checked %0d of %0d samples over %0d threshold settings", results_checked,
               samples_sent, settings_used);
      $display("Covered press edges, flag ageing, register extremes, a long output stall");
      $display("and idle sender and receiver phases, %0d mismatches", failures);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
